/* sv/stq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes for the sorted timer queue: opcodes, status codes,
// sequencer steps and the command/status groups between control and datapath.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int TIMER_COUNT_DEF = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int N_W             = 6;

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFREE   = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_SET0  = 15'b000000000000010,
        S_SET1  = 15'b000000000000100,
        S_LINK0 = 15'b000000000001000,
        S_SCAN  = 15'b000000000010000,
        S_INS2  = 15'b000000000100000,
        S_HEAD1 = 15'b000000001000000,
        S_HEAD2 = 15'b000000010000000,
        S_DONE  = 15'b000000100000000,
        S_CHK0  = 15'b000001000000000,
        S_CHK1  = 15'b000010000000000,
        S_TCHK  = 15'b000100000000000,
        S_TRD   = 15'b001000000000000,
        S_TCMP  = 15'b010000000000000,
        S_TEND  = 15'b100000000000000
    } state_t;

    typedef struct packed {
        state_t step;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       is_cancel;
        logic       fc_zero;
        logic       cnt_zero;
        logic       bad_hd;
        logic       dl_gt;
        logic       now_lt;
        logic       tick_new;
        logic       scan_last;
        logic       n_max;
        logic       pend;
        logic       out_free;
    } stat_t;

endpackage

/* sv/sorted_timer_queue_top.sv */
`timescale 1ns / 1ps
// Set and update place the entry by a tail-first list scan at one entry per cycle; cancel
// unlinks the entry; a tick removes expired entries from the head of the list. Output
// back-pressure holds the block until the result register is free.
// One request at a time; the next is taken once the final result is in the output register.
// Results leave through a registered output stage with valid/ready.
// Reset (asynchronous, active low) empties the list and restores the free stack.
// ----------------------------------------------------------------------------
// sorted_timer_queue_top
// Pool of timers kept in a deadline-ordered linked list, with set, cancel,
// update and tick requests.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top
    import stq_pkg::*;
#(
    parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [63:0] now_ms,
    input  logic [31:0] timeout_ms,
    input  logic [31:0] user_param,
    input  logic [4:0]  handle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [4:0]  out_handle,
    output logic [31:0] out_param,
    output logic        expired_valid,
    output logic        last
);

    cmd_t  cmd;
    stat_t st;

    stq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .st(st), .cmd(cmd)
    );

    stq_dp #(.TIMER_COUNT(TIMER_COUNT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .in_valid(in_valid), .opcode(opcode), .now_ms(now_ms),
        .timeout_ms(timeout_ms), .user_param(user_param), .handle(handle),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .out_handle(out_handle), .out_param(out_param),
        .expired_valid(expired_valid), .last(last)
    );

    assign in_ready = (cmd.step == S_IDLE);

`ifndef SYNTH
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while busy");

    a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && expired_valid) |-> (status == ST_OK))
        else $error("expiry with error status");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (last && !expired_valid))
        else $error("error result not final");
`endif

endmodule

/* sv/stq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/stq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for the timer queue: steps through set, cancel, update and tick.
// ----------------------------------------------------------------------------
module stq_ctrl
    import stq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (st.op)
                        OP_SET:  state_next = S_SET0;
                        OP_TICK: state_next = S_TCHK;
                        default: state_next = S_CHK0;
                    endcase
                end
            end
            S_SET0:
            begin
                if (!st.fc_zero)
                    state_next = S_SET1;
                else if (st.out_free)
                    state_next = S_IDLE;
            end
            S_SET1:  state_next = S_LINK0;
            S_LINK0: state_next = st.cnt_zero ? S_DONE : S_SCAN;
            S_SCAN:
            begin
                if (st.dl_gt)
                    state_next = S_INS2;
                else if (st.scan_last)
                    state_next = S_HEAD1;
            end
            S_INS2:  state_next = S_DONE;
            S_HEAD1: state_next = S_HEAD2;
            S_HEAD2: state_next = S_DONE;
            S_DONE:
            begin
                if (st.out_free)
                    state_next = S_IDLE;
            end
            S_CHK0:
            begin
                if (!st.bad_hd)
                    state_next = S_CHK1;
                else if (st.out_free)
                    state_next = S_IDLE;
            end
            S_CHK1:  state_next = st.is_cancel ? S_DONE : S_LINK0;
            S_TCHK:
            begin
                if (st.tick_new)
                    state_next = S_TRD;
                else if (st.out_free)
                    state_next = S_IDLE;
            end
            S_TRD:   state_next = (st.cnt_zero || st.n_max) ? S_TEND : S_TCMP;
            S_TCMP:
            begin
                if (st.now_lt)
                    state_next = S_TEND;
                else if (!(st.pend && !st.out_free))
                    state_next = S_TRD;
            end
            S_TEND:
            begin
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign cmd.step = state_reg;

endmodule

/* sv/stq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_dp
// Timer queue datapath: entry stores, list links, free stack, list pointers,
// counters and the result register.
// ----------------------------------------------------------------------------
module stq_dp
    import stq_pkg::*;
#(
    parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       st,
    input  logic        in_valid,
    input  logic [1:0]  opcode,
    input  logic [63:0] now_ms,
    input  logic [31:0] timeout_ms,
    input  logic [31:0] user_param,
    input  logic [4:0]  handle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [4:0]  out_handle,
    output logic [31:0] out_param,
    output logic        expired_valid,
    output logic        last
);

    localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CW = $clog2(TIMER_COUNT + 1);
    localparam logic [CW-1:0] TC_C = CW'(TIMER_COUNT);

    logic [1:0]  op_reg, op_next;
    logic [63:0] now_reg, now_next;
    logic [31:0] ivl_reg, ivl_next;
    logic [31:0] up_reg, up_next;
    logic [4:0]  hd_reg, hd_next;
    logic [IW-1:0] h_reg, h_next, pos_reg, pos_next, nxt_reg, nxt_next;
    logic [IW-1:0] head_reg, head_next, tail_reg, tail_next, ph_reg, ph_next;
    logic [63:0] dl_reg, dl_next, last_reg, last_next;
    logic [CW-1:0] i_reg, i_next, cnt_reg, cnt_next, fc_reg, fc_next;
    logic [N_W-1:0] n_reg, n_next;
    logic        pend_reg, pend_next;
    logic [31:0] pp_reg, pp_next;
    logic [TIMER_COUNT-1:0] armed_reg, armed_next, fsv_reg, fsv_next;
    logic        ov_reg, ov_next;
    logic [1:0]  ost_reg, ost_next;
    logic [4:0]  oh_reg, oh_next;
    logic [31:0] op_par_reg, op_par_next;
    logic        oev_reg, oev_next, olast_reg, olast_next;

    logic [IW-1:0] raddr, hd_idx, pop_pos, push_pos, h_new;
    logic [63:0] dl_rd, dl_wd;
    logic [31:0] per_rd, par_rd;
    logic [IW-1:0] nxt_rd, prv_rd, fs_rd;
    logic        dl_we, per_we, par_we, nxt_we, prv_we, fs_we;
    logic [IW-1:0] dl_wa, sp_wa, nxt_wa, prv_wa, fs_wa;
    logic [IW-1:0] nxt_wd, prv_wd, fs_wd;
    logic        out_free;

    stq_ram #(.WIDTH(64), .DEPTH(TIMER_COUNT)) u_dl_ram (
        .clk(clk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd), .raddr(raddr), .rdata(dl_rd));
    stq_ram #(.WIDTH(32), .DEPTH(TIMER_COUNT)) u_per_ram (
        .clk(clk), .we(per_we), .waddr(sp_wa), .wdata(ivl_reg), .raddr(raddr),
        .rdata(per_rd));
    stq_ram #(.WIDTH(32), .DEPTH(TIMER_COUNT)) u_par_ram (
        .clk(clk), .we(par_we), .waddr(sp_wa), .wdata(up_reg), .raddr(raddr),
        .rdata(par_rd));
    stq_ram #(.WIDTH(IW), .DEPTH(TIMER_COUNT)) u_nxt_ram (
        .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(raddr),
        .rdata(nxt_rd));
    stq_ram #(.WIDTH(IW), .DEPTH(TIMER_COUNT)) u_prv_ram (
        .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(raddr),
        .rdata(prv_rd));
    stq_ram #(.WIDTH(IW), .DEPTH(TIMER_COUNT)) u_fs_ram (
        .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd), .raddr(pop_pos),
        .rdata(fs_rd));

    assign hd_idx   = IW'(hd_reg);
    assign pop_pos  = IW'(TC_C - fc_reg);
    assign push_pos = IW'(TC_C - fc_reg - 1'b1);
    assign h_new    = fsv_reg[pop_pos] ? fs_rd : pop_pos;
    assign out_free = !ov_reg || out_ready;

    assign st.op        = opcode;
    assign st.is_cancel = (op_reg == OP_CANCEL);
    assign st.fc_zero   = (fc_reg == '0);
    assign st.cnt_zero  = (cnt_reg == '0);
    assign st.bad_hd    = (int'(hd_reg) >= TIMER_COUNT) || !armed_reg[hd_idx];
    assign st.dl_gt     = dl_reg > dl_rd;
    assign st.now_lt    = now_reg < dl_rd;
    assign st.tick_new  = now_reg > last_reg;
    assign st.scan_last = (CW'(i_reg + 1'b1) == cnt_reg);
    assign st.n_max     = (n_reg == N_W'(MAX_RESULTS));
    assign st.pend      = pend_reg;
    assign st.out_free  = out_free;

    always_comb
    begin
        op_next = op_reg;  now_next = now_reg;  ivl_next = ivl_reg;
        up_next = up_reg;  hd_next = hd_reg;    h_next = h_reg;
        pos_next = pos_reg; nxt_next = nxt_reg; head_next = head_reg;
        tail_next = tail_reg; ph_next = ph_reg; dl_next = dl_reg;
        last_next = last_reg; i_next = i_reg;   cnt_next = cnt_reg;
        fc_next = fc_reg;  n_next = n_reg;      pend_next = pend_reg;
        pp_next = pp_reg;  armed_next = armed_reg; fsv_next = fsv_reg;
        ov_next = ov_reg && !out_ready;
        ost_next = ost_reg; oh_next = oh_reg;   op_par_next = op_par_reg;
        oev_next = oev_reg; olast_next = olast_reg;
        raddr = h_reg;
        dl_we = 1'b0;  dl_wa = h_reg;  dl_wd = dl_reg;
        per_we = 1'b0; par_we = 1'b0;  sp_wa = h_reg;
        nxt_we = 1'b0; nxt_wa = h_reg; nxt_wd = h_reg;
        prv_we = 1'b0; prv_wa = h_reg; prv_wd = h_reg;
        fs_we = 1'b0;  fs_wa = push_pos; fs_wd = h_reg;

        case (cmd.step)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = opcode;
                    now_next = now_ms;
                    ivl_next = timeout_ms;
                    up_next  = user_param;
                    hd_next  = handle;
                end
            end
            S_SET0:
            begin
                if (fc_reg == '0 && out_free)
                begin
                    ov_next = 1'b1; ost_next = ST_NOFREE; oh_next = '0;
                    op_par_next = '0; oev_next = 1'b0; olast_next = 1'b1;
                end
            end
            S_SET1:
            begin
                h_next  = h_new;
                fc_next = fc_reg - 1'b1;
                dl_next = now_reg + {32'd0, ivl_reg};
                dl_we = 1'b1; dl_wa = h_new; dl_wd = now_reg + {32'd0, ivl_reg};
                per_we = 1'b1; par_we = 1'b1; sp_wa = h_new;
                armed_next[h_new] = 1'b1;
            end
            S_LINK0:
            begin
                raddr = tail_reg;
                if (cnt_reg == '0)
                begin
                    head_next = h_reg;
                    tail_next = h_reg;
                    nxt_we = 1'b1;
                    prv_we = 1'b1;
                    cnt_next = CW'(1);
                end
                else
                begin
                    pos_next = tail_reg;
                    i_next   = '0;
                end
            end
            S_SCAN:
            begin
                raddr = prv_rd;
                if (dl_reg > dl_rd)
                begin
                    nxt_we = 1'b1; nxt_wd = nxt_rd;
                    prv_we = 1'b1; prv_wd = pos_reg;
                    nxt_next = nxt_rd;
                end
                else
                begin
                    i_next   = i_reg + 1'b1;
                    pos_next = prv_rd;
                end
            end
            S_INS2:
            begin
                if (pos_reg == tail_reg)
                    tail_next = h_reg;
                else
                begin
                    prv_we = 1'b1; prv_wa = nxt_reg;
                end
                nxt_we = 1'b1; nxt_wa = pos_reg;
                cnt_next = cnt_reg + 1'b1;
            end
            S_HEAD1:
            begin
                nxt_we = 1'b1; nxt_wd = head_reg;
                prv_we = 1'b1;
            end
            S_HEAD2:
            begin
                prv_we = 1'b1; prv_wa = head_reg;
                head_next = h_reg;
                cnt_next = cnt_reg + 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1; ost_next = ST_OK; oh_next = 5'(h_reg);
                    op_par_next = '0; oev_next = 1'b0; olast_next = 1'b1;
                end
            end
            S_CHK0:
            begin
                raddr = hd_idx;
                if (st.bad_hd && out_free)
                begin
                    ov_next = 1'b1; ost_next = ST_INACTIVE; oh_next = hd_reg;
                    op_par_next = '0; oev_next = 1'b0; olast_next = 1'b1;
                end
            end
            S_CHK1:
            begin
                h_next = hd_idx;
                if (hd_idx == head_reg)
                    head_next = nxt_rd;
                else
                begin
                    nxt_we = 1'b1; nxt_wa = prv_rd; nxt_wd = nxt_rd;
                end
                if (hd_idx == tail_reg)
                    tail_next = prv_rd;
                else
                begin
                    prv_we = 1'b1; prv_wa = nxt_rd; prv_wd = prv_rd;
                end
                cnt_next = cnt_reg - 1'b1;
                if (op_reg == OP_CANCEL)
                begin
                    armed_next[hd_idx] = 1'b0;
                    fs_we = 1'b1; fs_wd = hd_idx;
                    fsv_next[push_pos] = 1'b1;
                    fc_next = fc_reg + 1'b1;
                end
                else
                begin
                    dl_next = now_reg + {32'd0, per_rd};
                    dl_we = 1'b1; dl_wa = hd_idx; dl_wd = now_reg + {32'd0, per_rd};
                end
            end
            S_TCHK:
            begin
                if (now_reg > last_reg)
                begin
                    last_next = now_reg;
                    n_next    = '0;
                    pend_next = 1'b0;
                end
                else if (out_free)
                begin
                    ov_next = 1'b1; ost_next = ST_OK; oh_next = '0;
                    op_par_next = '0; oev_next = 1'b0; olast_next = 1'b1;
                end
            end
            S_TRD:
            begin
                raddr = head_reg;
            end
            S_TCMP:
            begin
                raddr = head_reg;
                if (!(now_reg < dl_rd) && !(pend_reg && !out_free))
                begin
                    head_next = nxt_rd;
                    cnt_next  = cnt_reg - 1'b1;
                    armed_next[head_reg] = 1'b0;
                    fs_we = 1'b1; fs_wd = head_reg;
                    fsv_next[push_pos] = 1'b1;
                    fc_next = fc_reg + 1'b1;
                    if (pend_reg)
                    begin
                        ov_next = 1'b1; ost_next = ST_OK; oh_next = 5'(ph_reg);
                        op_par_next = pp_reg; oev_next = 1'b1; olast_next = 1'b0;
                    end
                    pend_next = 1'b1;
                    ph_next   = head_reg;
                    pp_next   = par_rd;
                    n_next    = n_reg + 1'b1;
                end
            end
            S_TEND:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1; ost_next = ST_OK; olast_next = 1'b1;
                    oh_next = pend_reg ? 5'(ph_reg) : 5'd0;
                    op_par_next = pend_reg ? pp_reg : 32'd0;
                    oev_next = pend_reg;
                end
            end
            default:
            begin
                raddr = h_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            fc_reg    <= TC_C;
            last_reg  <= '0;
            n_reg     <= '0;
            pend_reg  <= 1'b0;
            armed_reg <= '0;
            fsv_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            fc_reg    <= fc_next;
            last_reg  <= last_next;
            n_reg     <= n_next;
            pend_reg  <= pend_next;
            armed_reg <= armed_next;
            fsv_reg   <= fsv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        now_reg    <= now_next;
        ivl_reg    <= ivl_next;
        up_reg     <= up_next;
        hd_reg     <= hd_next;
        h_reg      <= h_next;
        pos_reg    <= pos_next;
        nxt_reg    <= nxt_next;
        ph_reg     <= ph_next;
        pp_reg     <= pp_next;
        dl_reg     <= dl_next;
        i_reg      <= i_next;
        ost_reg    <= ost_next;
        oh_reg     <= oh_next;
        op_par_reg <= op_par_next;
        oev_reg    <= oev_next;
        olast_reg  <= olast_next;
    end

    assign out_valid     = ov_reg;
    assign status        = ost_reg;
    assign out_handle    = oh_reg;
    assign out_param     = op_par_reg;
    assign expired_valid = oev_reg;
    assign last          = olast_reg;

endmodule
